// ===== design/indexed_triangle_normal_macros.svh =====
// Assertion macros shared by the indexed triangle normal block.
`ifndef INDEXED_TRIANGLE_NORMAL_MACROS_SVH
`define INDEXED_TRIANGLE_NORMAL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ITN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itn check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ITN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itn check failed");

`endif

// ===== design/itn_pkg.sv =====
// Types, widths, codes and helpers shared by the triangle normal block.
package itn_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_W   = $clog2(VERTEX_COUNT);
    localparam int IDX_W    = 10;
    localparam int POS_W    = 16;
    localparam int OUT_W    = 17;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;

    localparam int VTX_W   = 3 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int MAG_W   = 2 * COORD_BITS + 1;
    localparam int N_W     = MAG_W + 1;
    localparam int LO_W    = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int MUL_W   = ((DIFF_W > LO_W) ? DIFF_W : LO_W) + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int S_W     = SQ_W + 2;
    // The target length 65535 enters as 4 * 65535^2 = 2^34 - 2^19 + 2^2.
    localparam int SCALE_W    = 34;
    localparam int SCALE_SH_HI  = 34;
    localparam int SCALE_SH_MID = 19;
    localparam int SCALE_SH_LO  = 2;
    localparam int R_W     = SQ_W + SCALE_W;
    localparam int Q_W     = 34;
    localparam int ROOT_W  = Q_W / 2;
    localparam int SR_W    = ROOT_W + 3;
    localparam int CNT_W   = $clog2(Q_W);

    // Item kinds on the input tuser.
    localparam logic OPC_WRITE  = 1'b0;
    localparam logic OPC_NORMAL = 1'b1;

    // Datapath operations.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT     = 5'd1;
    localparam logic [OP_W-1:0] OP_RD_B       = 5'd2;
    localparam logic [OP_W-1:0] OP_RD_C       = 5'd3;
    localparam logic [OP_W-1:0] OP_LAT_C      = 5'd4;
    localparam logic [OP_W-1:0] OP_EDGE       = 5'd5;
    localparam logic [OP_W-1:0] OP_CR_MUL     = 5'd6;
    localparam logic [OP_W-1:0] OP_CR_ACC     = 5'd7;
    localparam logic [OP_W-1:0] OP_SQ_MUL     = 5'd8;
    localparam logic [OP_W-1:0] OP_SQ_ACC     = 5'd9;
    localparam logic [OP_W-1:0] OP_SQ_ADD     = 5'd10;
    localparam logic [OP_W-1:0] OP_SC1        = 5'd11;
    localparam logic [OP_W-1:0] OP_SC2        = 5'd12;
    localparam logic [OP_W-1:0] OP_DIV_INIT   = 5'd13;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 5'd14;
    localparam logic [OP_W-1:0] OP_SQRT_INIT  = 5'd15;
    localparam logic [OP_W-1:0] OP_SQRT_STEP  = 5'd16;
    localparam logic [OP_W-1:0] OP_FIN        = 5'd17;
    localparam logic [OP_W-1:0] OP_OUT        = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      k;
        logic [1:0]      part;
    } itn_cmd_t;

    typedef struct packed {
        logic s_zero;
    } itn_status_t;

    // Reduces an index modulo VERTEX_COUNT with a short chain of compare-subtracts.
    function automatic logic [ADDR_W-1:0] wrap_index(input logic [IDX_W-1:0] idx);
        int v;
        v = int'(idx);
        for (int i = IDX_W - 1; i >= 0; i--)
        begin
            if (v >= (VERTEX_COUNT << i))
            begin
                v = v - (VERTEX_COUNT << i);
            end
        end
        return ADDR_W'(v);
    endfunction

endpackage

// ===== design/itn_ram.sv =====
// Generic single-port RAM with registered read data.
module itn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/itn_ctrl.sv =====
// Sequencer that steps the triangle normal datapath through its operations.
module itn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output itn_pkg::itn_cmd_t   cmd,
    input  itn_pkg::itn_status_t status
);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_RD_B      = 5'd1;
    localparam logic [4:0] ST_RD_C      = 5'd2;
    localparam logic [4:0] ST_LAT_C     = 5'd3;
    localparam logic [4:0] ST_EDGE      = 5'd4;
    localparam logic [4:0] ST_CR_MUL    = 5'd5;
    localparam logic [4:0] ST_CR_ACC    = 5'd6;
    localparam logic [4:0] ST_SQ_MUL    = 5'd7;
    localparam logic [4:0] ST_SQ_ACC    = 5'd8;
    localparam logic [4:0] ST_SQ_ADD    = 5'd9;
    localparam logic [4:0] ST_SC1       = 5'd10;
    localparam logic [4:0] ST_SC2       = 5'd11;
    localparam logic [4:0] ST_DIV_INIT  = 5'd12;
    localparam logic [4:0] ST_DIV       = 5'd13;
    localparam logic [4:0] ST_SQRT_INIT = 5'd14;
    localparam logic [4:0] ST_SQRT      = 5'd15;
    localparam logic [4:0] ST_FIN       = 5'd16;
    localparam logic [4:0] ST_OUT       = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] part_reg, part_next;
    logic [itn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg;
    logic load_out;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        cmd.op     = itn_pkg::OP_NOP;
        cmd.k      = k_reg;
        cmd.part   = part_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = itn_pkg::OP_ACCEPT;
                    if (in_opcode == itn_pkg::OPC_NORMAL)
                    begin
                        state_next = ST_RD_B;
                    end
                end
            end
            ST_RD_B:
            begin
                cmd.op     = itn_pkg::OP_RD_B;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.op     = itn_pkg::OP_RD_C;
                state_next = ST_LAT_C;
            end
            ST_LAT_C:
            begin
                cmd.op     = itn_pkg::OP_LAT_C;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                cmd.op     = itn_pkg::OP_EDGE;
                k_next     = 2'd0;
                part_next  = 2'd0;
                state_next = ST_CR_MUL;
            end
            ST_CR_MUL:
            begin
                cmd.op     = itn_pkg::OP_CR_MUL;
                state_next = ST_CR_ACC;
            end
            ST_CR_ACC:
            begin
                cmd.op = itn_pkg::OP_CR_ACC;
                if (part_reg == 2'd0)
                begin
                    part_next  = 2'd1;
                    state_next = ST_CR_MUL;
                end
                else
                begin
                    part_next = 2'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_SQ_MUL;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_CR_MUL;
                    end
                end
            end
            ST_SQ_MUL:
            begin
                cmd.op     = itn_pkg::OP_SQ_MUL;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                cmd.op = itn_pkg::OP_SQ_ACC;
                if (part_reg == 2'd2)
                begin
                    part_next  = 2'd0;
                    state_next = ST_SQ_ADD;
                end
                else
                begin
                    part_next  = part_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_ADD:
            begin
                cmd.op = itn_pkg::OP_SQ_ADD;
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = ST_SC1;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SC1:
            begin
                cmd.op = itn_pkg::OP_SC1;
                // A zero squared length needs no scaling at all.
                if (status.s_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SC2;
                end
            end
            ST_SC2:
            begin
                cmd.op     = itn_pkg::OP_SC2;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.op     = itn_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = itn_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == itn_pkg::CNT_W'(itn_pkg::Q_W - 1))
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = itn_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = itn_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == itn_pkg::CNT_W'(itn_pkg::ROOT_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.op = itn_pkg::OP_FIN;
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_SC1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = itn_pkg::OP_OUT;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= 2'd0;
            part_reg      <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            part_reg  <= part_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/itn_datapath.sv =====
// Vertex memory, shared multiplier, divider and square root for the normal.
module itn_datapath (
    input  logic                              clk,
    input  logic                              in_opcode,
    input  logic [itn_pkg::IDX_W-1:0]         vertex_slot,
    input  logic signed [itn_pkg::POS_W-1:0]  pos_x,
    input  logic signed [itn_pkg::POS_W-1:0]  pos_y,
    input  logic signed [itn_pkg::POS_W-1:0]  pos_z,
    input  logic [itn_pkg::IDX_W-1:0]         corner_a,
    input  logic [itn_pkg::IDX_W-1:0]         corner_b,
    input  logic [itn_pkg::IDX_W-1:0]         corner_c,
    input  itn_pkg::itn_cmd_t                 cmd,
    output itn_pkg::itn_status_t              status,
    output logic signed [itn_pkg::OUT_W-1:0]  normal_x,
    output logic signed [itn_pkg::OUT_W-1:0]  normal_y,
    output logic signed [itn_pkg::OUT_W-1:0]  normal_z,
    output logic                              degenerate
);

    localparam int CB = itn_pkg::COORD_BITS;

    logic [itn_pkg::ADDR_W-1:0] ram_addr;
    logic                       ram_we;
    logic [itn_pkg::VTX_W-1:0]  ram_wr_data;
    logic [itn_pkg::VTX_W-1:0]  ram_rd_data;

    logic [itn_pkg::ADDR_W-1:0] cb_reg, cc_reg;
    logic [itn_pkg::VTX_W-1:0]  va_reg, vb_reg;

    logic signed [itn_pkg::DIFF_W-1:0] e1_reg [3];
    logic signed [itn_pkg::DIFF_W-1:0] e2_reg [3];
    logic signed [itn_pkg::N_W-1:0]    n_reg [3];
    logic [itn_pkg::SQ_W-1:0]          msq_reg [3];
    logic signed [itn_pkg::OUT_W-1:0]  res_reg [3];

    logic signed [itn_pkg::PROD_W-1:0] prod_reg;
    logic [itn_pkg::SQ_W-1:0]          sq_reg;
    logic [itn_pkg::S_W-1:0]           s_reg;
    logic [itn_pkg::R_W-1:0]           r_reg;
    logic [itn_pkg::S_W-1:0]           drem_reg;
    logic [itn_pkg::Q_W-1:0]           dlo_reg;
    logic [itn_pkg::Q_W-1:0]           q_reg;
    logic [itn_pkg::Q_W-1:0]           rad_reg;
    logic [itn_pkg::SR_W-1:0]          srem_reg;
    logic [itn_pkg::ROOT_W-1:0]        root_reg;

    logic signed [itn_pkg::OUT_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic                              deg_reg;

    logic signed [itn_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [itn_pkg::DIFF_W-1:0] d_p, d_q, d_r, d_s;
    logic signed [itn_pkg::N_W-1:0]    n_cur;
    logic [itn_pkg::MAG_W-1:0]         mag;
    logic [itn_pkg::MUL_W-1:0]         hi_ext, lo_ext;
    logic [itn_pkg::SQ_W-1:0]          prod_ext;
    logic [itn_pkg::R_W-1:0]           msq_ext;
    logic [itn_pkg::S_W:0]             div_trial;
    logic [itn_pkg::SR_W-1:0]          sq_cur, sq_trial;
    logic [itn_pkg::ROOT_W:0]          m_sum;
    logic [itn_pkg::OUT_W-1:0]         m_ext;

    itn_ram #(
        .WIDTH(itn_pkg::VTX_W),
        .DEPTH(itn_pkg::VERTEX_COUNT)
    ) u_vertex_ram (
        .clk    (clk),
        .we     (ram_we),
        .addr   (ram_addr),
        .wr_data(ram_wr_data),
        .rd_data(ram_rd_data)
    );

    assign ram_wr_data = {pos_z[CB-1:0], pos_y[CB-1:0], pos_x[CB-1:0]};
    assign ram_we = (cmd.op == itn_pkg::OP_ACCEPT) && (in_opcode == itn_pkg::OPC_WRITE);

    always_comb
    begin
        unique case (cmd.op)
            itn_pkg::OP_ACCEPT:
            begin
                ram_addr = (in_opcode == itn_pkg::OPC_WRITE) ?
                           itn_pkg::wrap_index(vertex_slot) : itn_pkg::wrap_index(corner_a);
            end
            itn_pkg::OP_RD_B: ram_addr = cb_reg;
            default:          ram_addr = cc_reg;
        endcase
    end

    // Component k of e1 x e2 is e1[k+1]*e2[k+2] - e1[k+2]*e2[k+1], indices mod 3.
    always_comb
    begin
        case (cmd.k)
            2'd0:
            begin
                d_p = e1_reg[1]; d_q = e2_reg[2]; d_r = e1_reg[2]; d_s = e2_reg[1];
            end
            2'd1:
            begin
                d_p = e1_reg[2]; d_q = e2_reg[0]; d_r = e1_reg[0]; d_s = e2_reg[2];
            end
            default:
            begin
                d_p = e1_reg[0]; d_q = e2_reg[1]; d_r = e1_reg[1]; d_s = e2_reg[0];
            end
        endcase
    end

    assign n_cur  = n_reg[cmd.k];
    assign mag    = n_cur[itn_pkg::N_W-1] ? itn_pkg::MAG_W'(-n_cur) : itn_pkg::MAG_W'(n_cur);
    assign hi_ext = itn_pkg::MUL_W'(mag[itn_pkg::MAG_W-1:itn_pkg::LO_W]);
    assign lo_ext = itn_pkg::MUL_W'(mag[itn_pkg::LO_W-1:0]);

    always_comb
    begin
        if (cmd.op == itn_pkg::OP_CR_MUL)
        begin
            if (cmd.part == 2'd0)
            begin
                mul_a = itn_pkg::MUL_W'(d_p);
                mul_b = itn_pkg::MUL_W'(d_q);
            end
            else
            begin
                mul_a = itn_pkg::MUL_W'(d_r);
                mul_b = itn_pkg::MUL_W'(d_s);
            end
        end
        else
        begin
            case (cmd.part)
                2'd0:
                begin
                    mul_a = $signed(hi_ext); mul_b = $signed(hi_ext);
                end
                2'd1:
                begin
                    mul_a = $signed(hi_ext); mul_b = $signed(lo_ext);
                end
                default:
                begin
                    mul_a = $signed(lo_ext); mul_b = $signed(lo_ext);
                end
            endcase
        end
    end

    assign prod_ext = itn_pkg::SQ_W'($unsigned(prod_reg));
    assign msq_ext  = itn_pkg::R_W'(msq_reg[cmd.k]);
    assign div_trial = {drem_reg, dlo_reg[itn_pkg::Q_W-1]};
    assign sq_cur   = {srem_reg[itn_pkg::SR_W-3:0], rad_reg[itn_pkg::Q_W-1:itn_pkg::Q_W-2]};
    assign sq_trial = itn_pkg::SR_W'({root_reg, 2'b01});
    assign m_sum    = {1'b0, root_reg} + 1'b1;
    assign m_ext    = itn_pkg::OUT_W'(m_sum[itn_pkg::ROOT_W:1]);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            itn_pkg::OP_ACCEPT:
            begin
                cb_reg <= itn_pkg::wrap_index(corner_b);
                cc_reg <= itn_pkg::wrap_index(corner_c);
            end
            itn_pkg::OP_RD_B: va_reg <= ram_rd_data;
            itn_pkg::OP_RD_C: vb_reg <= ram_rd_data;
            itn_pkg::OP_LAT_C:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= itn_pkg::DIFF_W'($signed(vb_reg[i*CB +: CB]))
                               - itn_pkg::DIFF_W'($signed(va_reg[i*CB +: CB]));
                    e2_reg[i] <= itn_pkg::DIFF_W'($signed(ram_rd_data[i*CB +: CB]))
                               - itn_pkg::DIFF_W'($signed(vb_reg[i*CB +: CB]));
                end
            end
            itn_pkg::OP_EDGE:
            begin
                s_reg <= '0;
            end
            itn_pkg::OP_CR_MUL, itn_pkg::OP_SQ_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            itn_pkg::OP_CR_ACC:
            begin
                if (cmd.part == 2'd0)
                begin
                    n_reg[cmd.k] <= itn_pkg::N_W'(prod_reg);
                end
                else
                begin
                    n_reg[cmd.k] <= itn_pkg::N_W'(itn_pkg::PROD_W'(n_cur) - prod_reg);
                end
            end
            itn_pkg::OP_SQ_ACC:
            begin
                case (cmd.part)
                    2'd0:    sq_reg <= prod_ext << (2 * itn_pkg::LO_W);
                    2'd1:    sq_reg <= sq_reg + (prod_ext << (itn_pkg::LO_W + 1));
                    default: sq_reg <= sq_reg + prod_ext;
                endcase
            end
            itn_pkg::OP_SQ_ADD:
            begin
                s_reg <= s_reg + itn_pkg::S_W'(sq_reg);
                msq_reg[cmd.k] <= sq_reg;
            end
            itn_pkg::OP_SC1:
            begin
                r_reg <= (msq_ext << itn_pkg::SCALE_SH_HI) + (msq_ext << itn_pkg::SCALE_SH_LO);
            end
            itn_pkg::OP_SC2:
            begin
                r_reg <= r_reg - (msq_ext << itn_pkg::SCALE_SH_MID);
            end
            itn_pkg::OP_DIV_INIT:
            begin
                // The quotient fits Q_W bits, so the top part is already below s.
                drem_reg <= itn_pkg::S_W'(r_reg >> itn_pkg::Q_W);
                dlo_reg  <= r_reg[itn_pkg::Q_W-1:0];
                q_reg    <= '0;
            end
            itn_pkg::OP_DIV_STEP:
            begin
                dlo_reg <= dlo_reg << 1;
                if (div_trial >= {1'b0, s_reg})
                begin
                    drem_reg <= itn_pkg::S_W'(div_trial - {1'b0, s_reg});
                    q_reg    <= {q_reg[itn_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= itn_pkg::S_W'(div_trial);
                    q_reg    <= {q_reg[itn_pkg::Q_W-2:0], 1'b0};
                end
            end
            itn_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= q_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            itn_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= rad_reg << 2;
                if (sq_cur >= sq_trial)
                begin
                    srem_reg <= sq_cur - sq_trial;
                    root_reg <= {root_reg[itn_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sq_cur;
                    root_reg <= {root_reg[itn_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            itn_pkg::OP_FIN:
            begin
                // The largest odd k with k <= isqrt(q) is 2m - 1, so m = (root + 1) / 2.
                res_reg[cmd.k] <= n_cur[itn_pkg::N_W-1] ? -$signed(m_ext) : $signed(m_ext);
            end
            itn_pkg::OP_OUT:
            begin
                deg_reg <= status.s_zero;
                nx_reg  <= status.s_zero ? '0 : res_reg[0];
                ny_reg  <= status.s_zero ? '0 : res_reg[1];
                nz_reg  <= status.s_zero ? '0 : res_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    assign status.s_zero = (s_reg == '0);
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = deg_reg;

endmodule

// ===== design/indexed_triangle_normal.sv =====
// Top level of the indexed triangle normal block.
// The block holds a memory of VERTEX_COUNT vertices and computes unit-length
// (65535) face normals of triangles given by three vertex indices.
// Input beats arrive on the s_axis channel. tuser selects the kind: a vertex
// write stores pos_x/y/z at vertex_slot and produces no output beat; a normal
// request reads corner_a, corner_b and corner_c and produces one output beat.
// A write beat leaves the block idle, so the next beat can follow at once.
// A degenerate triangle skips the scaling, the divider and the square
// root. Otherwise most of the time goes to a 34-step restoring divider
// and a 17-step square root, run once for each of the three components,
// plus the shared 18x18 multiplier that forms the cross product and the
// squared length.
// One item is worked on at a time; s_axis_tready is high only while idle.
// The output beat waits in a register, so a new item is accepted while the
// receiver stalls; a finished result then waits until that register empties.
// Reset clears the control state only; the vertex memory is not cleared and
// must be written before any vertex is read.
module indexed_triangle_normal (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [itn_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // normal_x, normal_y, normal_z, zero padding
    output logic [itn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]  m_axis_tuser
);

`include "indexed_triangle_normal_macros.svh"

    itn_pkg::itn_cmd_t    cmd;
    itn_pkg::itn_status_t status;

    logic signed [itn_pkg::OUT_W-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    itn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_opcode(s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    itn_datapath u_datapath (
        .clk        (clk),
        .in_opcode  (s_axis_tuser[0]),
        .vertex_slot(s_axis_tdata[9:0]),
        .pos_x      (s_axis_tdata[25:10]),
        .pos_y      (s_axis_tdata[41:26]),
        .pos_z      (s_axis_tdata[57:42]),
        .corner_a   (s_axis_tdata[67:58]),
        .corner_b   (s_axis_tdata[77:68]),
        .corner_c   (s_axis_tdata[87:78]),
        .cmd        (cmd),
        .status     (status),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

    assign m_axis_tdata = {5'b0, normal_z, normal_y, normal_x};
    assign m_axis_tuser = degenerate;

    `ITN_ASSERT_NEXT(a_busy_after_request,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == itn_pkg::OPC_NORMAL),
        !s_axis_tready)

    `ITN_ASSERT_NEXT(a_ready_after_write,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == itn_pkg::OPC_WRITE),
        s_axis_tready)

    `ITN_ASSERT_NOW(a_degenerate_is_zero,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

    `ITN_ASSERT_NOW(a_load_only_when_free,
        cmd.op == itn_pkg::OP_OUT, !m_axis_tvalid || m_axis_tready)

endmodule

// ===== verif/tb_indexed_triangle_normal.sv =====
// Self-checking testbench for the indexed triangle normal block.
module tb_indexed_triangle_normal;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        opc;
        logic [9:0]  slot;
        logic [15:0] px, py, pz;
        logic [9:0]  ca, cb, cc;
    } tri_item_t;

    typedef struct {
        logic [16:0] nx, ny, nz;
        logic        degen;
    } normal_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [itn_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic [0:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [itn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    indexed_triangle_normal dut (.*);

    tri_item_t pending_items[$];
    normal_t   expected_normals[$];
    longint    vx[1024], vy[1024], vz[1024];
    bit        written[1024];
    int        fail_count = 0;
    bit        hold_active;
    int        send_gap;
    int        recv_gap;
    bit        in_taken;
    bit        out_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounded 65535*m/sqrt(s), ties away from zero; searches with exact integers.
    function automatic logic [16:0] scale_component(longint n, logic [127:0] s);
        logic [127:0] m, rhs, lhs, k;
        longint lo, hi, mid;
        m = 128'((n < 0) ? -n : n);
        rhs = m * m * 128'(64'd131070 * 64'd131070);
        lo = 0;
        hi = 65535;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k = 128'(2 * mid - 1);
            lhs = s * k * k;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (n < 0) ? 17'(-lo) : 17'(lo);
    endfunction

    function automatic void predict_normal(tri_item_t it);
        longint e1[3], e2[3], n[3];
        logic [127:0] s, m;
        normal_t r;
        int a, b, c;
        if (it.opc == itn_pkg::OPC_WRITE)
        begin
            vx[it.slot] = longint'($signed(it.px));
            vy[it.slot] = longint'($signed(it.py));
            vz[it.slot] = longint'($signed(it.pz));
            return;
        end
        a = int'(it.ca);
        b = int'(it.cb);
        c = int'(it.cc);
        e1[0] = vx[b] - vx[a]; e1[1] = vy[b] - vy[a]; e1[2] = vz[b] - vz[a];
        e2[0] = vx[c] - vx[b]; e2[1] = vy[c] - vy[b]; e2[2] = vz[c] - vz[b];
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        // Squares can exceed 64 bits, so they are formed from 128-bit magnitudes.
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = 128'((n[i] < 0) ? -n[i] : n[i]);
            s = s + m * m;
        end
        r.degen = (s == '0);
        r.nx = r.degen ? 17'd0 : scale_component(n[0], s);
        r.ny = r.degen ? 17'd0 : scale_component(n[1], s);
        r.nz = r.degen ? 17'd0 : scale_component(n[2], s);
        expected_normals.push_back(r);
    endfunction

    function automatic void add_write(int slot, int x, int y, int z);
        tri_item_t it;
        it.opc = itn_pkg::OPC_WRITE;
        it.slot = 10'(slot);
        it.px = 16'(x); it.py = 16'(y); it.pz = 16'(z);
        it.ca = 10'($urandom); it.cb = 10'($urandom); it.cc = 10'($urandom);
        written[slot] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic void add_triangle(int a, int b, int c);
        tri_item_t it;
        it.opc = itn_pkg::OPC_NORMAL;
        it.slot = 10'($urandom);
        it.px = 16'($urandom); it.py = 16'($urandom); it.pz = 16'($urandom);
        it.ca = 10'(a); it.cb = 10'(b); it.cc = 10'(c);
        pending_items.push_back(it);
    endfunction

    function automatic int pick_written();
        int s;
        do s = int'($urandom_range(0, 1023)); while (!written[s]);
        return s;
    endfunction

    // Waits until every queued item was taken and every expected result has come.
    task automatic wait_drained();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid)
            @(posedge clk);
        wait (expected_normals.size() == 0);
    endtask

    // Driver: one item per beat, random gap after each.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
            // The offered beat has not been taken yet, so it stays as it is.
        end
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_items.size() > 0)
        begin
            tri_item_t it;
            it = pending_items.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= it.opc;
            s_axis_tdata <= {it.cc, it.cb, it.ca, it.pz, it.py, it.px, it.slot};
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Accept handler on the input side: predicts as items enter the block.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            tri_item_t it;
            {it.cc, it.cb, it.ca, it.pz, it.py, it.px, it.slot} = s_axis_tdata[87:0];
            it.opc = s_axis_tuser[0];
            predict_normal(it);
        end
    end

    // Long receiver stall right after reset while the sender keeps offering items.
    initial
    begin
        hold_active = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (1500) @(posedge clk);
        hold_active = 1'b0;
    end

    // Receiver readiness: a random wait after each accepted result beat.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            int gap;
            gap = out_taken ? (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17)))
                            : recv_gap;
            if (hold_active || gap > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
            if (!hold_active && gap > 0)
                gap = gap - 1;
            recv_gap <= gap;
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        out_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            normal_t e;
            if (expected_normals.size() == 0)
            begin
                $error("unexpected result beat %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_normals.pop_front();
                if (m_axis_tdata[16:0] !== e.nx)
                begin
                    $error("normal_x expected %0d actual %0d", $signed(e.nx),
                           $signed(m_axis_tdata[16:0]));
                    fail_count++;
                end
                if (m_axis_tdata[33:17] !== e.ny)
                begin
                    $error("normal_y expected %0d actual %0d", $signed(e.ny),
                           $signed(m_axis_tdata[33:17]));
                    fail_count++;
                end
                if (m_axis_tdata[50:34] !== e.nz)
                begin
                    $error("normal_z expected %0d actual %0d", $signed(e.nz),
                           $signed(m_axis_tdata[50:34]));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== e.degen)
                begin
                    $error("degenerate expected %0d actual %0d", e.degen, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int a, b, c;
        rst_n = 1'b0;
        // Directed: extreme coordinates, wrapped corners, degenerate shapes.
        add_write(0, 16'h8000, 16'h8000, 16'h8000);
        add_write(1, 16'h7fff, 16'h8000, 16'h8000);
        add_write(2, 16'h8000, 16'h7fff, 16'h8000);
        add_write(1023, 16'h8000, 16'h8000, 16'h7fff);
        add_write(512, 16'h7fff, 16'h7fff, 16'h7fff);
        add_write(3, 0, 0, 0);
        add_write(4, 16'hffff, 16'hffff, 16'hffff);
        add_triangle(0, 1, 2);
        add_triangle(0, 2, 1);
        add_triangle(1, 2, 1023);
        add_triangle(1023, 512, 0);
        add_triangle(0, 0, 0);
        add_triangle(3, 4, 512);
        add_triangle(0, 512, 3);
        add_triangle(1, 1, 2);
        add_triangle(2, 1023, 1);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();
        repeat (250) @(posedge clk);
        // Random part: mostly triangles on written vertices, some rewrites.
        for (int i = 0; i < 580; i++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                case ($urandom_range(0, 2))
                    0: add_write($urandom_range(0, 1023), $urandom, $urandom, $urandom);
                    1: add_write($urandom_range(0, 1023), $urandom_range(0, 7) - 4,
                                 $urandom_range(0, 7) - 4, $urandom_range(0, 7) - 4);
                    default: add_write($urandom_range(0, 1023),
                                       $urandom_range(0, 1) ? 16'h7fff : 16'h8000,
                                       $urandom, $urandom_range(0, 1) ? 16'h7fff : 16'h8000);
                endcase
            end
            else
            begin
                a = pick_written();
                b = ($urandom_range(0, 9) == 0) ? a : pick_written();
                c = pick_written();
                add_triangle(a, b, c);
            end
            if (i == 290)
            begin
                // Sender pause until the block has drained.
                wait_drained();
                repeat (250) @(posedge clk);
            end
        end
        wait_drained();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && expected_normals.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
